// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define MWF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define MWF_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mwf_pkg.sv =====
`timescale 1ns / 1ps
package mwf_pkg;
    localparam int CHANNELS_DEF   = 4;
    localparam int WINDOW_LEN_DEF = 8;

    localparam int SAMPLE_W = 32;
    localparam int THR_W    = 16;
    localparam int KIND_W   = 3;
    localparam int CHAN_W   = 2;

    localparam logic [THR_W-1:0] THR_RESET = 16'd3277;

    // result selector codes
    localparam logic [KIND_W-1:0] K_TRIM   = 3'd0;
    localparam logic [KIND_W-1:0] K_MODE   = 3'd1;
    localparam logic [KIND_W-1:0] K_MEDIAN = 3'd2;
    localparam logic [KIND_W-1:0] K_SMOOTH = 3'd3;
    localparam logic [KIND_W-1:0] K_MAX    = 3'd4;
    localparam logic [KIND_W-1:0] K_MIN    = 3'd5;
    localparam logic [KIND_W-1:0] K_NONE   = 3'd6;
endpackage

// ===== rtl/multichannel_window_filter.sv =====
`timescale 1ns / 1ps
// Multichannel sliding-window filter. Each input word carries one signed Q16.16 sample, the
// channel whose ring window of WINDOW_LEN samples takes it, and a kind that picks the answer:
// trimmed mean (max and min dropped), most frequent value (ties to the earliest slot), upper
// median, smooth hold (one held value shared by all channels, updated when the window mean is
// positive and max and min lie within mean*smooth_threshold/65536 of it), maximum, minimum,
// or zero. A channel beyond CHANNELS leaves all state alone and answers zero. All windows
// sit in one memory with a single registered read port, and every step reads one sample
// through it, so that port sets the rate: each word is written, then its whole window is
// scanned for sum, maximum and minimum. Max, min and zero answers follow the scan directly;
// median and most frequent add a compare of every slot against every slot; trimmed mean
// adds a divide by a constant done as a reciprocal multiply in 16-bit digit steps; smooth
// hold adds the limit products and their compare, plus the divide when the held value
// updates. A result still waiting in the output register holds the next word back for as
// long as it waits. The input is not ready while a word is in work. After reset a clearing
// pass zeroes every window entry in turn before the first word is taken; threshold writes
// are taken at any time.
module multichannel_window_filter #(
    parameter int CHANNELS   = mwf_pkg::CHANNELS_DEF,
    parameter int WINDOW_LEN = mwf_pkg::WINDOW_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // sample [31:0]
    input  logic [7:0]  i_s_tuser,   // channel [1:0], kind [4:2], zero [7:5]
    // result words
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // filtered_value [31:0]
    // threshold write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // smooth_threshold [15:0]
);
    `include "assert_macros.svh"

    localparam int DEPTH = CHANNELS * WINDOW_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(WINDOW_LEN);
    localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW    = $clog2(WINDOW_LEN + 1);
    localparam int SW    = 33 + IW;          // window sum
    localparam int PW    = SW + 18;          // smooth-hold products
    // reciprocal divide: 16-bit multiplier digits, most significant first
    localparam int MC      = (SW + 2 + 15) / 16;
    localparam int MW      = 16 * MC;
    localparam int ACW     = SW + MW;
    localparam int PRW     = SW + 16;
    localparam int QCW     = $clog2(MC + 1);
    localparam int SH_TRIM = SW + $clog2(WINDOW_LEN - 2);
    localparam int SH_MEAN = SW + $clog2(WINDOW_LEN);
    localparam logic [MW-1:0] REC_TRIM =
        MW'(((longint'(1) << SH_TRIM) + longint'(WINDOW_LEN - 3)) / longint'(WINDOW_LEN - 2));
    localparam logic [MW-1:0] REC_MEAN =
        MW'(((longint'(1) << SH_MEAN) + longint'(WINDOW_LEN - 1)) / longint'(WINDOW_LEN));

    localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_LEN - 1);
    localparam logic [CW-1:0] HALF     = CW'(WINDOW_LEN / 2);
    localparam logic signed [PW-1:0] N_S = PW'(WINDOW_LEN);

    // sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WRITE  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_DISP   = 4'd4;
    localparam logic [3:0] S_OUTER  = 4'd5;
    localparam logic [3:0] S_LOADI  = 4'd6;
    localparam logic [3:0] S_INNER  = 4'd7;
    localparam logic [3:0] S_SM_MUL = 4'd8;
    localparam logic [3:0] S_SM_CMP = 4'd9;
    localparam logic [3:0] S_DIVSET = 4'd10;
    localparam logic [3:0] S_DIV    = 4'd11;
    localparam logic [3:0] S_DIVEND = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0]            r_state, n_state;
    logic [AW-1:0]         r_clr, n_clr;
    logic [15:0]           r_thr;
    logic [IW-1:0]         r_wslot [CHANNELS];
    logic [IW-1:0]         n_wslot [CHANNELS];
    logic signed [31:0]    r_held, n_held;
    logic signed [31:0]    r_sample, n_sample;
    logic [CIW-1:0]        r_chi, n_chi;
    logic [2:0]            r_kind, n_kind;
    logic [AW-1:0]         r_base, n_base;
    logic [IW-1:0]         r_wr_idx, n_wr_idx;
    logic [IW-1:0]         r_addr_idx, n_addr_idx;
    logic                  r_prim, n_prim;
    logic [IW-1:0]         r_j, n_j;
    logic [IW-1:0]         r_i, n_i;
    logic signed [SW-1:0]  r_sum, n_sum;
    logic signed [31:0]    r_mx, n_mx;
    logic signed [31:0]    r_mn, n_mn;
    logic signed [31:0]    r_vi, n_vi;
    logic [CW-1:0]         r_ceq, n_ceq;
    logic [CW-1:0]         r_clt, n_clt;
    logic [CW-1:0]         r_cle, n_cle;
    logic [CW-1:0]         r_best, n_best;
    logic signed [31:0]    r_pick, n_pick;
    logic signed [31:0]    r_med, n_med;
    logic signed [SW-1:0]  r_num, n_num;
    logic [SW-1:0]         r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [MW-1:0]         r_rec, n_rec;
    logic [ACW-1:0]        r_acc, n_acc;
    logic [QCW-1:0]        r_dcnt, n_dcnt;
    logic                  r_div_held, n_div_held;
    logic signed [PW-1:0]  r_lim, n_lim;
    logic signed [PW-1:0]  r_dmax, n_dmax;
    logic signed [PW-1:0]  r_dmin, n_dmin;
    logic [31:0]           r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    logic [31:0]           r_out_data, n_out_data;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [31:0]           ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [31:0]           ram_rdata;
    logic signed [31:0]    rd_s;

    logic                  s_accept;
    logic [CW-1:0]         f_eq, f_lt, f_le;
    logic [PRW-1:0]        mul_p;
    logic [31:0]           q_mag;
    logic [31:0]           q_signed;

    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    assign rd_s = signed'(ram_rdata);

    // window memory: clearing pass, sample write, one read a cycle
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : (r_base + AW'(r_wr_idx));
    assign ram_wdata = (r_state == S_CLEAR) ? 32'd0 : r_sample;
    assign ram_raddr = r_base + AW'(r_addr_idx);

    mwf_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // pair compare of the inner loop, folded into the running counts
    always_comb begin
        f_eq = r_ceq + CW'(((rd_s == r_vi) && (r_j >= r_i)) ? 1 : 0);
        f_lt = r_clt + CW'((rd_s < r_vi) ? 1 : 0);
        f_le = r_cle + CW'((rd_s <= r_vi) ? 1 : 0);
    end

    // divide by a constant: magnitude times reciprocal, one 16-bit digit a step
    always_comb begin
        mul_p    = PRW'(r_mag) * PRW'(r_rec[MW-1 -: 16]);
        q_mag    = r_div_held ? r_acc[SH_MEAN +: 32] : r_acc[SH_TRIM +: 32];
        q_signed = r_neg ? (32'd0 - q_mag) : q_mag;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_wslot     = r_wslot;
        n_held      = r_held;
        n_sample    = r_sample;
        n_chi       = r_chi;
        n_kind      = r_kind;
        n_base      = r_base;
        n_wr_idx    = r_wr_idx;
        n_addr_idx  = r_addr_idx;
        n_prim      = r_prim;
        n_j         = r_j;
        n_i         = r_i;
        n_sum       = r_sum;
        n_mx        = r_mx;
        n_mn        = r_mn;
        n_vi        = r_vi;
        n_ceq       = r_ceq;
        n_clt       = r_clt;
        n_cle       = r_cle;
        n_best      = r_best;
        n_pick      = r_pick;
        n_med       = r_med;
        n_num       = r_num;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_rec       = r_rec;
        n_acc       = r_acc;
        n_dcnt      = r_dcnt;
        n_div_held  = r_div_held;
        n_lim       = r_lim;
        n_dmax      = r_dmax;
        n_dmin      = r_dmin;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_sample = signed'(i_s_tdata);
                    n_kind   = i_s_tuser[4:2];
                    n_chi    = CIW'(i_s_tuser[1:0]);
                    n_base   = AW'(32'(i_s_tuser[1:0]) * WINDOW_LEN);
                    if (32'(i_s_tuser[1:0]) >= CHANNELS) begin
                        // unknown channel: nothing stored, answer zero
                        n_res   = 32'd0;
                        n_state = S_DONE;
                    end else begin
                        n_wr_idx = r_wslot[CIW'(i_s_tuser[1:0])];
                        n_state  = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                n_wslot[r_chi] = (r_wr_idx == LAST_IDX) ? IW'(0) : (r_wr_idx + IW'(1));
                n_addr_idx     = IW'(0);
                n_prim         = 1'b0;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                if (!r_prim) begin
                    n_prim     = 1'b1;
                    n_addr_idx = IW'(1);
                    n_j        = IW'(0);
                end else begin
                    n_addr_idx = r_addr_idx + IW'(1);
                    if (r_j == IW'(0)) begin
                        n_sum = SW'(rd_s);
                        n_mx  = rd_s;
                        n_mn  = rd_s;
                    end else begin
                        n_sum = r_sum + SW'(rd_s);
                        n_mx  = (rd_s > r_mx) ? rd_s : r_mx;
                        n_mn  = (rd_s < r_mn) ? rd_s : r_mn;
                    end
                    if (r_j == LAST_IDX) begin
                        n_state = S_DISP;
                    end else begin
                        n_j = r_j + IW'(1);
                    end
                end
            end
            S_DISP: begin
                unique case (r_kind)
                    mwf_pkg::K_TRIM: begin
                        n_num      = r_sum - SW'(r_mx) - SW'(r_mn);
                        n_div_held = 1'b0;
                        n_state    = S_DIVSET;
                    end
                    mwf_pkg::K_MODE, mwf_pkg::K_MEDIAN: begin
                        n_i        = IW'(0);
                        n_addr_idx = IW'(0);
                        n_best     = CW'(0);
                        n_state    = S_OUTER;
                    end
                    mwf_pkg::K_SMOOTH: begin
                        if (r_sum > SW'(0)) begin
                            n_state = S_SM_MUL;
                        end else begin
                            n_res   = r_held;
                            n_state = S_DONE;
                        end
                    end
                    mwf_pkg::K_MAX: begin
                        n_res   = r_mx;
                        n_state = S_DONE;
                    end
                    mwf_pkg::K_MIN: begin
                        n_res   = r_mn;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_res   = 32'd0;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_OUTER: begin
                n_addr_idx = IW'(0);
                n_state    = S_LOADI;
            end
            S_LOADI: begin
                n_vi       = rd_s;
                n_addr_idx = IW'(1);
                n_j        = IW'(0);
                n_ceq      = CW'(0);
                n_clt      = CW'(0);
                n_cle      = CW'(0);
                n_state    = S_INNER;
            end
            S_INNER: begin
                n_addr_idx = r_addr_idx + IW'(1);
                n_ceq      = f_eq;
                n_clt      = f_lt;
                n_cle      = f_le;
                if (r_j == LAST_IDX) begin
                    // strict greater keeps the earliest slot on ties
                    if (f_eq > r_best) begin
                        n_best = f_eq;
                        n_pick = r_vi;
                    end
                    // slot value sits at sorted index half
                    if ((f_lt <= HALF) && (f_le > HALF)) begin
                        n_med = r_vi;
                    end
                    if (r_i == LAST_IDX) begin
                        if (r_kind == mwf_pkg::K_MODE) begin
                            n_res = (f_eq > r_best) ? r_vi : r_pick;
                        end else begin
                            n_res = ((f_lt <= HALF) && (f_le > HALF)) ? r_vi : r_med;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_i        = r_i + IW'(1);
                        n_addr_idx = r_i + IW'(1);
                        n_state    = S_OUTER;
                    end
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            S_SM_MUL: begin
                n_lim   = PW'(signed'({1'b0, r_thr})) * PW'(r_sum);
                n_dmax  = N_S * PW'(r_mx) - PW'(r_sum);
                n_dmin  = PW'(r_sum) - N_S * PW'(r_mn);
                n_state = S_SM_CMP;
            end
            S_SM_CMP: begin
                if (((r_dmax <<< 16) < r_lim) && ((r_dmin <<< 16) < r_lim)) begin
                    n_num      = r_sum;
                    n_div_held = 1'b1;
                    n_state    = S_DIVSET;
                end else begin
                    n_res   = r_held;
                    n_state = S_DONE;
                end
            end
            S_DIVSET: begin
                n_neg   = r_num[SW-1];
                n_mag   = r_num[SW-1] ? (SW'(0) - unsigned'(r_num)) : unsigned'(r_num);
                n_rec   = r_div_held ? REC_MEAN : REC_TRIM;
                n_acc   = ACW'(0);
                n_dcnt  = QCW'(MC);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_acc  = {r_acc[ACW-17:0], 16'd0} + ACW'(mul_p);
                n_rec  = {r_rec[MW-17:0], 16'd0};
                n_dcnt = r_dcnt - QCW'(1);
                if (r_dcnt == QCW'(1)) begin
                    n_state = S_DIVEND;
                end
            end
            S_DIVEND: begin
                n_res = q_signed;
                if (r_div_held) begin
                    n_held = signed'(q_signed);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // output register frees the core while the result waits
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= AW'(0);
            r_thr       <= mwf_pkg::THR_RESET;
            r_held      <= 32'sd0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wslot[c] <= IW'(0);
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            r_wslot     <= n_wslot;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_chi      <= n_chi;
        r_kind     <= n_kind;
        r_base     <= n_base;
        r_wr_idx   <= n_wr_idx;
        r_addr_idx <= n_addr_idx;
        r_prim     <= n_prim;
        r_j        <= n_j;
        r_i        <= n_i;
        r_sum      <= n_sum;
        r_mx       <= n_mx;
        r_mn       <= n_mn;
        r_vi       <= n_vi;
        r_ceq      <= n_ceq;
        r_clt      <= n_clt;
        r_cle      <= n_cle;
        r_best     <= n_best;
        r_pick     <= n_pick;
        r_med      <= n_med;
        r_num      <= n_num;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_rec      <= n_rec;
        r_acc      <= n_acc;
        r_dcnt     <= n_dcnt;
        r_div_held <= n_div_held;
        r_lim      <= n_lim;
        r_dmax     <= n_dmax;
        r_dmin     <= n_dmin;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    `MWF_ASSERT(a_accept_starts, i_clk, i_rst_n, s_accept |=> ((r_state == S_WRITE) || (r_state == S_DONE)), "accepted word did not start work")
    `MWF_ASSERT(a_done_delivers, i_clk, i_rst_n, ((r_state == S_DONE) && !r_out_valid) |=> (r_out_valid && (r_state == S_IDLE)), "finished result not registered")
    `MWF_ASSERT(a_div_count, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_dcnt != QCW'(0)), "divider digit count out of range")
endmodule

// ===== rtl/mwf_ram.sv =====
`timescale 1ns / 1ps
module mwf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== tb/tb_multichannel_window_filter.sv =====
`timescale 1ns / 1ps
module tb_multichannel_window_filter;

    localparam int NCH    = mwf_pkg::CHANNELS_DEF;
    localparam int WLEN   = mwf_pkg::WINDOW_LEN_DEF;
    localparam int LIMIT  = 2000000;

    typedef struct packed {
        logic [31:0] sample;
        logic [1:0]  channel;
        logic [2:0]  kind;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [7:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    multichannel_window_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic signed [31:0] win [NCH][WLEN];
    int unsigned        wslot [NCH];
    logic signed [31:0] held_value;
    logic [15:0]        thr;

    t_reading           pending_words[$];
    logic [31:0]        expected_values[$];
    int                 errors;
    int                 sent_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    logic               send_hold;
    longint             cycle_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: %s got %h want %h at cycle %0d", what, got, want, cycle_count);
        errors++;
    endtask

    // expected filtered value for one accepted word, advances predictor state
    function automatic logic [31:0] predict_filtered(input t_reading r);
        logic signed [31:0] w [WLEN];
        logic signed [31:0] t [WLEN];
        logic signed [31:0] v;
        longint             total, mx, mn, lim;
        int                 cnt, best, pick, j;
        if (r.channel >= NCH) return 32'd0;
        win[r.channel][wslot[r.channel]] = r.sample;
        wslot[r.channel] = (wslot[r.channel] + 1) % WLEN;
        w = win[r.channel];
        total = 0;
        mx = w[0];
        mn = w[0];
        for (int i = 0; i < WLEN; i++) begin
            total += w[i];
            if (w[i] > mx) mx = w[i];
            if (w[i] < mn) mn = w[i];
        end
        case (r.kind)
            mwf_pkg::K_TRIM: return 32'((total - mx - mn) / longint'(WLEN - 2));
            mwf_pkg::K_MODE: begin
                best = 0;
                pick = 0;
                for (int i = 0; i < WLEN; i++) begin
                    cnt = 0;
                    for (int k = i; k < WLEN; k++) if (w[i] == w[k]) cnt++;
                    if (cnt > best) begin
                        best = cnt;
                        pick = i;
                    end
                end
                return w[pick];
            end
            mwf_pkg::K_MEDIAN: begin
                t = w;
                for (int i = 1; i < WLEN; i++) begin
                    v = t[i];
                    j = i;
                    while (j > 0 && t[j-1] > v) begin
                        t[j] = t[j-1];
                        j--;
                    end
                    t[j] = v;
                end
                return t[WLEN/2];
            end
            mwf_pkg::K_SMOOTH: begin
                if (total > 0) begin
                    lim = longint'(thr) * total;
                    if ((WLEN * mx - total) * 65536 < lim && (total - WLEN * mn) * 65536 < lim)
                        held_value = 32'(total / WLEN);
                end
                return held_value;
            end
            mwf_pkg::K_MAX: return 32'(mx);
            mwf_pkg::K_MIN: return 32'(mn);
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($urandom_range(0, 6)) << 16;
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'h0010_0000 + $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic t_reading make_word(input logic [31:0] s, input int ch, input int k);
        t_reading r;
        r.sample  = s;
        r.channel = 2'(ch);
        r.kind    = 3'(k);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // driver: sender idles at random, holds off while send_hold is set and results are due
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= '0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) sent_count++;
            if (pending_words.size() > 0 &&
                !(send_hold && (i_s_tvalid || expected_values.size() > 0)) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                t_reading r;
                r = pending_words.pop_front();
                expected_values.push_back(predict_filtered(r));
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= r.sample;
                i_s_tuser  <= {3'b000, r.kind, r.channel};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_values.size() == 0)
                    report_mismatch("unexpected word", o_m_tdata, 32'hx);
                else begin
                    logic [31:0] want;
                    want = expected_values.pop_front();
                    if (o_m_tdata !== want) report_mismatch("filtered_value", o_m_tdata, want);
                end
            end
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("** multichannel_window_filter: FAILED **");
            $finish;
        end
    end

    // wait until every queued word has gone out and every result has come back
    task automatic drain();
        while (pending_words.size() > 0 || i_s_tvalid || expected_values.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        thr = value;
    endtask

    task automatic random_phase(input int count);
        int ch, k;
        logic [31:0] base;
        for (int n = 0; n < count; n++) begin
            ch = $urandom_range(0, NCH - 1);
            k  = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) begin
                // near-flat window so smooth hold can update
                base = 32'h0001_0000 + $urandom_range(0, 32'h00FF_FFFF);
                for (int i = 0; i < WLEN; i++)
                    pending_words.push_back(make_word(base + $urandom_range(0, 2000), ch,
                        (i == WLEN - 1) ? mwf_pkg::K_SMOOTH : $urandom_range(0, 7)));
                n += WLEN - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                // few distinct values exercise most frequent and median ties
                pending_words.push_back(make_word(32'($urandom_range(0, 3)), ch, k));
            end else begin
                pending_words.push_back(make_word(rand_sample(), ch, k));
            end
        end
    endtask

    initial begin
        for (int c = 0; c < NCH; c++) begin
            wslot[c] = 0;
            for (int i = 0; i < WLEN; i++) win[c][i] = '0;
        end
        held_value    = '0;
        thr           = mwf_pkg::THR_RESET;
        errors        = 0;
        sent_count    = 0;
        cycle_count   = 0;
        send_hold     = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 55;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = '0;
        i_m_tready    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every kind on zero windows, extremes, unused kind
        for (int k = 0; k < 8; k++) pending_words.push_back(make_word(32'd0, 0, k));
        pending_words.push_back(make_word(32'h7FFF_FFFF, 1, mwf_pkg::K_MAX));
        pending_words.push_back(make_word(32'h8000_0000, 1, mwf_pkg::K_MIN));
        pending_words.push_back(make_word(32'hFFFF_FFFF, 1, mwf_pkg::K_TRIM));
        pending_words.push_back(make_word(32'h8000_0000, 1, mwf_pkg::K_SMOOTH));
        for (int i = 0; i < WLEN; i++)
            pending_words.push_back(make_word(32'h0005_0000 + i, 3, mwf_pkg::K_SMOOTH));
        pending_words.push_back(make_word(32'hFFFB_0000, 2, mwf_pkg::K_SMOOTH));
        pending_words.push_back(make_word(32'h0001_0000, 2, mwf_pkg::K_MEDIAN));
        pending_words.push_back(make_word(32'h0001_0000, 2, mwf_pkg::K_MODE));
        drain();

        // pressure: sender waits until every result is in before the next word
        send_hold = 1'b1;
        random_phase(20);
        drain();
        send_hold = 1'b0;

        write_threshold(16'd0);
        random_phase(250);
        drain();
        write_threshold(16'hFFFF);
        random_phase(300);
        drain();

        send_idle_pct = 55;
        recv_idle_pct = 19;
        write_threshold(16'(mwf_pkg::THR_RESET));
        random_phase(300);
        drain();
        write_threshold(16'($urandom()));
        random_phase(250);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(16'd64);
        random_phase(550);
        drain();

        if (errors == 0) begin
            $display("** multichannel_window_filter: PASSED **");
        end else begin
            $display("** multichannel_window_filter: FAILED **");
        end
        $finish;
    end
endmodule
